// File: sv/sync_crc8_frame_receiver_core_defines.svh
// assertion helpers used by the framer
`ifndef SYNC_CRC8_FRAME_RECEIVER_CORE_DEFINES_SVH
`define SYNC_CRC8_FRAME_RECEIVER_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked outside reset
`define SCFR_ASSERT_IMP(lbl, pre, post) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |-> (post)) \
        else $error("scfr assertion failed");

// next-cycle implication, checked outside reset
`define SCFR_ASSERT_NXT(lbl, pre, post) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error("scfr assertion failed");

`else

`define SCFR_ASSERT_IMP(lbl, pre, post)
`define SCFR_ASSERT_NXT(lbl, pre, post)

`endif

`endif

// File: sv/scfr_pkg.sv
package scfr_pkg;

    // sync word after reset, first byte in the top eight bits
    localparam logic [31:0] SYNC_WORD_RESET = 32'h8025_232E;

    // crc-8 generator polynomial, msb first
    localparam logic [7:0] CRC_POLY = 8'h07;

    // ring slots
    localparam int SLOT_COUNT = 16;
    localparam int SLOT_W = (SLOT_COUNT > 2) ? $clog2(SLOT_COUNT) : 1;
    typedef logic [SLOT_W-1:0] slot_t;
    localparam slot_t SLOT_LAST = SLOT_W'(SLOT_COUNT - 1);

    // queue between hunter and framer
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
    typedef logic [QPTR_W-1:0] qptr_t;
    typedef logic [QCNT_W-1:0] qcnt_t;
    localparam qptr_t QPTR_LAST = QPTR_W'(QUEUE_DEPTH - 1);
    localparam qcnt_t QCNT_FULL = QCNT_W'(QUEUE_DEPTH);

    // frame phase
    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_CHECK = 2'd1,
        PH_LEN   = 2'd2,
        PH_DATA  = 2'd3
    } phase_t;

    // input word
    typedef struct packed {
        logic [7:0] rx_byte;
        logic       sink_accepts;
    } s_word_t;

    // result word
    typedef struct packed {
        logic [3:0] slot;
        logic [7:0] offset;
        logic [7:0] data;
        logic       last;
        logic       crc_ok;
        logic       handed_off;
    } m_word_t;

    // classified word held in the queue
    typedef struct packed {
        logic       restart;
        logic [7:0] rx_byte;
        logic       sink_accepts;
    } q_word_t;

    // crc-8 over one byte, bitwise msb first
    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// File: sv/sync_crc8_frame_receiver_core.sv
// a data byte accepted at the input is registered in the queue and then in the output register before m_valid shows it
// throughput: one byte per cycle while the output is not stalled, set by the combinational crc-8 update in the framer
// a two-word queue between sync hunter and framer absorbs output stalls
// reset (aresetn low, synchronous): sync word 0x8025232E, slot 0, first byte is a check byte
// no clearing pass, the block is ready as soon as reset is released
module sync_crc8_frame_receiver_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  logic [31:0]       cfg_wdata,
    input  logic              s_valid,
    output logic              s_ready,
    input  scfr_pkg::s_word_t s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output scfr_pkg::m_word_t m_data
);

    logic              push;
    logic              q_in_ready;
    scfr_pkg::q_word_t q_in_data;
    logic              q_out_valid;
    logic              pop;
    scfr_pkg::q_word_t q_out_data;

    // sync hunting and word classification
    scfr_hunter u_hunter (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .q_push    (push),
        .q_ready   (q_in_ready),
        .q_data    (q_in_data)
    );

    // decoupling queue
    scfr_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .in_ready  (q_in_ready),
        .in_data   (q_in_data),
        .out_valid (q_out_valid),
        .pop       (pop),
        .out_data  (q_out_data)
    );

    // framing, crc check and result register
    scfr_framer u_framer (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_out_valid),
        .q_pop   (pop),
        .q_data  (q_out_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

// File: sv/scfr_hunter.sv
module scfr_hunter (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  logic [31:0]       cfg_wdata,
    input  logic              s_valid,
    output logic              s_ready,
    input  scfr_pkg::s_word_t s_data,
    output logic              q_push,
    input  logic              q_ready,
    output scfr_pkg::q_word_t q_data
);

    logic [31:0] sync_word_reg;
    logic [1:0]  matched_reg;
    logic [1:0]  matched_next;
    logic [7:0]  expect_byte;
    logic [7:0]  first_byte;
    logic [2:0]  count;

    // sync byte expected after the bytes matched so far
    always_comb begin
        case (matched_reg)
            2'd0:    expect_byte = sync_word_reg[31:24];
            2'd1:    expect_byte = sync_word_reg[23:16];
            2'd2:    expect_byte = sync_word_reg[15:8];
            2'd3:    expect_byte = sync_word_reg[7:0];
            default: expect_byte = sync_word_reg[31:24];
        endcase
    end

    assign first_byte = sync_word_reg[31:24];

    // match count with restart on the first sync byte
    always_comb begin
        if (s_data.rx_byte == expect_byte) begin
            count = {1'b0, matched_reg} + 3'd1;
        end else if (s_data.rx_byte == first_byte) begin
            count = 3'd1;
        end else begin
            count = 3'd0;
        end
        matched_next = count[1:0];
    end

    // classify and hand on
    assign s_ready              = q_ready;
    assign q_push               = s_valid && q_ready;
    assign q_data.restart       = count[2];
    assign q_data.rx_byte       = s_data.rx_byte;
    assign q_data.sink_accepts  = s_data.sink_accepts;

    // sync word register and match counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sync_word_reg <= scfr_pkg::SYNC_WORD_RESET;
            matched_reg   <= 2'd0;
        end else begin
            if (cfg_we) begin
                sync_word_reg <= cfg_wdata;
            end
            if (q_push) begin
                matched_reg <= matched_next;
            end
        end
    end

endmodule

// File: sv/scfr_queue.sv
module scfr_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    output logic              in_ready,
    input  scfr_pkg::q_word_t in_data,
    output logic              out_valid,
    input  logic              pop,
    output scfr_pkg::q_word_t out_data
);

    scfr_pkg::q_word_t mem_reg [scfr_pkg::QUEUE_DEPTH];
    scfr_pkg::qptr_t   wr_ptr_reg;
    scfr_pkg::qptr_t   rd_ptr_reg;
    scfr_pkg::qcnt_t   cnt_reg;
    scfr_pkg::qcnt_t   cnt_next;

    assign in_ready  = (cnt_reg != scfr_pkg::QCNT_FULL);
    assign out_valid = (cnt_reg != '0);
    assign out_data  = mem_reg[rd_ptr_reg];

    // occupancy
    always_comb begin
        cnt_next = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    // storage, no reset
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_data;
        end
    end

    // pointers and count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            cnt_reg <= cnt_next;
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == scfr_pkg::QPTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == scfr_pkg::QPTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
        end
    end

endmodule

// File: sv/scfr_framer.sv
`include "sync_crc8_frame_receiver_core_defines.svh"

module scfr_framer (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              q_valid,
    output logic              q_pop,
    input  scfr_pkg::q_word_t q_data,
    output logic              m_valid,
    input  logic              m_ready,
    output scfr_pkg::m_word_t m_data
);

    scfr_pkg::phase_t  phase_reg;
    scfr_pkg::phase_t  phase_next;
    logic [7:0]        crc_reg;
    logic [7:0]        crc_next;
    logic [7:0]        check_reg;
    logic [7:0]        check_next;
    logic [7:0]        len_reg;
    logic [7:0]        len_next;
    logic [7:0]        pos_reg;
    logic [7:0]        pos_next;
    scfr_pkg::slot_t   slot_reg;
    scfr_pkg::slot_t   slot_next;
    logic              m_valid_reg;
    logic              m_valid_next;
    scfr_pkg::m_word_t m_data_reg;
    scfr_pkg::m_word_t m_data_next;
    logic [7:0]        crc_upd;
    logic [7:0]        slot_wide;
    logic              emit;
    logic              is_last;
    logic              ok;
    logic              hand;

    // take a word when the output register is free or draining
    assign q_pop     = q_valid && (!m_valid_reg || m_ready);
    assign crc_upd   = scfr_pkg::crc8_update(crc_reg, q_data.rx_byte);
    assign is_last   = (pos_reg == len_reg);
    assign ok        = (crc_upd == check_reg);
    assign hand      = ok && q_data.sink_accepts;
    assign slot_wide = 8'(slot_reg);

    // frame sequencing and result build
    always_comb begin
        phase_next  = phase_reg;
        crc_next    = crc_reg;
        check_next  = check_reg;
        len_next    = len_reg;
        pos_next    = pos_reg;
        slot_next   = slot_reg;
        emit        = 1'b0;
        m_data_next = m_data_reg;
        if (q_pop) begin
            if (q_data.restart) begin
                phase_next = scfr_pkg::PH_CHECK;
            end else begin
                case (phase_reg)
                    scfr_pkg::PH_CHECK: begin
                        crc_next   = 8'd0;
                        check_next = q_data.rx_byte;
                        phase_next = scfr_pkg::PH_LEN;
                    end
                    scfr_pkg::PH_LEN: begin
                        crc_next   = crc_upd;
                        len_next   = q_data.rx_byte;
                        pos_next   = 8'd0;
                        phase_next = scfr_pkg::PH_DATA;
                    end
                    scfr_pkg::PH_DATA: begin
                        crc_next               = crc_upd;
                        pos_next               = pos_reg + 8'd1;
                        emit                   = 1'b1;
                        m_data_next.slot       = slot_wide[3:0];
                        m_data_next.offset     = pos_reg;
                        m_data_next.data       = q_data.rx_byte;
                        m_data_next.last       = is_last;
                        m_data_next.crc_ok     = is_last && ok;
                        m_data_next.handed_off = is_last && hand;
                        if (is_last) begin
                            phase_next = scfr_pkg::PH_IDLE;
                            if (hand) begin
                                slot_next = (slot_reg == scfr_pkg::SLOT_LAST) ?
                                            '0 : slot_reg + 1'b1;
                            end
                        end
                    end
                    default: begin
                        phase_next = phase_reg;
                    end
                endcase
            end
        end
    end

    // output register valid
    always_comb begin
        if (emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= scfr_pkg::PH_CHECK;
            crc_reg     <= 8'd0;
            slot_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            phase_reg   <= phase_next;
            crc_reg     <= crc_next;
            slot_reg    <= slot_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // frame fields and result payload
    always_ff @(posedge aclk) begin
        check_reg  <= check_next;
        len_reg    <= len_next;
        pos_reg    <= pos_next;
        m_data_reg <= m_data_next;
    end

    // sync restart always reopens the frame
    `SCFR_ASSERT_NXT(a_restart_check, q_pop && q_data.restart, phase_reg == scfr_pkg::PH_CHECK)
    // final payload byte closes the frame
    `SCFR_ASSERT_NXT(a_last_idle, emit && is_last, phase_reg == scfr_pkg::PH_IDLE)
    // a stalled result blocks the queue
    `SCFR_ASSERT_IMP(a_stall_no_pop, m_valid_reg && !m_ready, !q_pop)

endmodule
